@@ rtl/bmm_pkg.sv @@
package bmm_pkg;

  localparam int MAX_AGENTS = 64;
  localparam int MAX_HOUSES = 64;
  localparam int MAX_PREFS  = 8;

  localparam int ID_W    = 7;
  localparam int SLOT_W  = 3;
  localparam int PCNT_W  = 4;
  localparam int DIST_W  = 7;
  localparam int CIDX_W  = 2;
  localparam int AGI_W   = $clog2(MAX_AGENTS);
  localparam int PREF_AW = AGI_W + SLOT_W;
  localparam int PREF_D  = MAX_AGENTS * MAX_PREFS;
  localparam int NODE_D  = MAX_AGENTS + 1;
  localparam int QUE_D   = MAX_AGENTS;
  localparam int QUE_AW  = $clog2(QUE_D);

  localparam logic [DIST_W-1:0] DIST_INF = '1;

  localparam logic [CIDX_W-1:0] REG_NUM_AGENTS = 2'd0;
  localparam logic [CIDX_W-1:0] REG_NUM_HOUSES = 2'd1;
  localparam logic [CIDX_W-1:0] REG_PREFS      = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CLR,
    ST_L_RD, ST_L_WR, ST_L_D0,
    ST_B_POP, ST_B_QA, ST_B_DA, ST_B_SLOT, ST_B_H, ST_B_O, ST_B_DO,
    ST_U_NEXT, ST_U_PT,
    ST_D_DA, ST_D_SLOT, ST_D_H, ST_D_O, ST_D_DO, ST_D_POP, ST_D_SUCC, ST_D_UPOP,
    ST_O_RD, ST_O_LD, ST_O_WAIT
  } bmm_state_t;

  typedef struct packed {
    logic house_ok;
    logic dist_inf;
    logic dist_next;
    logic below0;
  } bmm_cmp_t;

  typedef struct packed {
    logic [ID_W-1:0]   agent;
    logic [SLOT_W-1:0] slot;
    logic [DIST_W-1:0] lvl;
    logic [ID_W-1:0]   house;
  } bmm_frame_t;

endpackage

@@ rtl/bipartite_max_matching.sv @@
// Channel | Direction | Words
// in_     | input     | load one preference slot, or start a matching run
// out_    | output    | one word per agent after a run, last flagged
// cfg_    | input     | register write, always ready
//
// A start word first clears the partner tables, then runs layering and augmenting
// rounds with registered memory reads; the length of a run depends on the preference
// graph. Reset is synchronous, active low.
// The block takes no input word until the last result word is taken; results
// wait in the output register while out_ready is low.
module bipartite_max_matching import bmm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_req_type,
  input  logic [ID_W-1:0]   in_agent_id,
  input  logic [SLOT_W-1:0] in_slot_index,
  input  logic [ID_W-1:0]   in_house_id,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ID_W-1:0]   out_agent,
  output logic [ID_W-1:0]   out_assigned_house,
  output logic [ID_W-1:0]   out_matching_size,
  output logic              out_last_result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [ID_W-1:0]   cfg_data
);

  bmm_state_t state_r, state_nxt;

  logic [ID_W-1:0]   num_agents_r, num_houses_r;
  logic [PCNT_W-1:0] prefs_r;
  logic [ID_W-1:0]   cur_agents_r, cur_agents_nxt, cur_houses_r, cur_houses_nxt;
  logic [PCNT_W-1:0] cur_prefs_r, cur_prefs_nxt;
  logic [ID_W-1:0]   ag_r, ag_nxt, a_r, a_nxt, h_r, h_nxt, o_r, o_nxt;
  logic [PCNT_W-1:0] s_r, s_nxt;
  logic [DIST_W-1:0] da_r, da_nxt, dist0_r, dist0_nxt;
  logic [ID_W-1:0]   head_r, head_nxt, tail_r, tail_nxt, sp_r, sp_nxt;
  logic [ID_W-1:0]   pair_count_r, pair_count_nxt;
  logic [ID_W-1:0]   oag_r, oag_nxt, ohouse_r, ohouse_nxt;
  logic              olast_r, olast_nxt;

  // Memory ports.
  logic                 pref_we;
  logic [PREF_AW-1:0]   pref_waddr, pref_raddr;
  logic [ID_W-1:0]      pref_rd;
  logic                 ap_we, hp_we, dist_we, que_we, stk_we;
  logic [ID_W-1:0]      ap_waddr, ap_wdata, ap_raddr, ap_rd;
  logic [ID_W-1:0]      hp_waddr, hp_wdata, hp_raddr, hp_rd;
  logic [ID_W-1:0]      dist_waddr, dist_raddr;
  logic [DIST_W-1:0]    dist_wdata, dist_rd, dist_inc;
  logic [QUE_AW-1:0]    que_waddr, que_raddr, stk_waddr, stk_raddr;
  logic [ID_W-1:0]      que_wdata, que_rd;
  bmm_frame_t           stk_wdata, stk_rd;
  bmm_cmp_t             cmp;
  logic [ID_W-1:0]      a_m1, sp_m1;
  logic [ID_W-1:0]      ld_m1;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_O_WAIT);
  assign cfg_ready = 1'b1;
  assign out_agent          = oag_r;
  assign out_assigned_house = ohouse_r;
  assign out_matching_size  = pair_count_r;
  assign out_last_result    = olast_r;

  assign a_m1  = a_r - 1'b1;
  assign sp_m1 = sp_r - 1'b1;
  assign ld_m1 = in_agent_id - 1'b1;
  assign pref_raddr = {a_m1[AGI_W-1:0], s_r[SLOT_W-1:0]};
  assign pref_waddr = {ld_m1[AGI_W-1:0], in_slot_index};
  assign pref_we    = in_valid && in_ready && !in_req_type && (in_agent_id != '0) &&
                      (in_agent_id <= ID_W'(MAX_AGENTS));

  bmm_ram #(.W(ID_W), .D(PREF_D)) u_pref (
    .clk(clk), .we(pref_we), .waddr(pref_waddr), .wdata(in_house_id),
    .raddr(pref_raddr), .rdata(pref_rd));
  bmm_ram #(.W(ID_W), .D(NODE_D)) u_ap (
    .clk(clk), .we(ap_we), .waddr(ap_waddr), .wdata(ap_wdata),
    .raddr(ap_raddr), .rdata(ap_rd));
  bmm_ram #(.W(ID_W), .D(NODE_D)) u_hp (
    .clk(clk), .we(hp_we), .waddr(hp_waddr), .wdata(hp_wdata),
    .raddr(hp_raddr), .rdata(hp_rd));
  bmm_ram #(.W(DIST_W), .D(NODE_D)) u_dist (
    .clk(clk), .we(dist_we), .waddr(dist_waddr), .wdata(dist_wdata),
    .raddr(dist_raddr), .rdata(dist_rd));
  bmm_ram #(.W(ID_W), .D(QUE_D)) u_que (
    .clk(clk), .we(que_we), .waddr(que_waddr), .wdata(que_wdata),
    .raddr(que_raddr), .rdata(que_rd));
  bmm_ram #(.W($bits(bmm_frame_t)), .D(QUE_D)) u_stk (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rd));

  bmm_cmp u_cmp (
    .house(pref_rd), .cur_houses(cur_houses_r), .dist_rd(dist_rd),
    .dist_cur(da_r), .dist_zero(dist0_r), .dist_inc(dist_inc), .res(cmp));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      num_agents_r <= ID_W'(MAX_AGENTS);
      num_houses_r <= ID_W'(MAX_HOUSES);
      prefs_r      <= PCNT_W'(MAX_PREFS);
      head_r       <= '0;
      tail_r       <= '0;
      sp_r         <= '0;
      pair_count_r <= '0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      sp_r         <= sp_nxt;
      pair_count_r <= pair_count_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_NUM_AGENTS: num_agents_r <= cfg_data;
          REG_NUM_HOUSES: num_houses_r <= cfg_data;
          REG_PREFS:      prefs_r      <= cfg_data[PCNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_agents_r <= cur_agents_nxt;
    cur_houses_r <= cur_houses_nxt;
    cur_prefs_r  <= cur_prefs_nxt;
    ag_r     <= ag_nxt;
    a_r      <= a_nxt;
    h_r      <= h_nxt;
    o_r      <= o_nxt;
    s_r      <= s_nxt;
    da_r     <= da_nxt;
    dist0_r  <= dist0_nxt;
    oag_r    <= oag_nxt;
    ohouse_r <= ohouse_nxt;
    olast_r  <= olast_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cur_agents_nxt = cur_agents_r;
    cur_houses_nxt = cur_houses_r;
    cur_prefs_nxt  = cur_prefs_r;
    ag_nxt = ag_r;
    a_nxt  = a_r;
    h_nxt  = h_r;
    o_nxt  = o_r;
    s_nxt  = s_r;
    da_nxt = da_r;
    dist0_nxt = dist0_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    sp_nxt    = sp_r;
    pair_count_nxt = pair_count_r;
    oag_nxt    = oag_r;
    ohouse_nxt = ohouse_r;
    olast_nxt  = olast_r;
    ap_we = 1'b0;  ap_waddr = ag_r;  ap_wdata = '0;  ap_raddr = a_r;
    hp_we = 1'b0;  hp_waddr = ag_r;  hp_wdata = '0;  hp_raddr = pref_rd;
    dist_we = 1'b0; dist_waddr = a_r; dist_wdata = DIST_INF; dist_raddr = a_r;
    que_we = 1'b0; que_waddr = tail_r[QUE_AW-1:0]; que_wdata = a_r;
    que_raddr = head_r[QUE_AW-1:0];
    stk_we = 1'b0; stk_waddr = sp_r[QUE_AW-1:0];
    stk_wdata = '{agent: a_r, slot: s_r[SLOT_W-1:0], lvl: da_r, house: h_r};
    stk_raddr = sp_m1[QUE_AW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_req_type) begin
          cur_agents_nxt = (num_agents_r > ID_W'(MAX_AGENTS)) ? ID_W'(MAX_AGENTS)
                                                                : num_agents_r;
          cur_houses_nxt = (num_houses_r > ID_W'(MAX_HOUSES)) ? ID_W'(MAX_HOUSES)
                                                                : num_houses_r;
          cur_prefs_nxt  = (prefs_r > PCNT_W'(MAX_PREFS)) ? PCNT_W'(MAX_PREFS) : prefs_r;
          pair_count_nxt = '0;
          ag_nxt    = '0;
          state_nxt = ST_CLR;
        end
      end
      ST_CLR: begin
        ap_we = 1'b1;
        hp_we = 1'b1;
        ag_nxt = ag_r + 1'b1;
        if (ag_r == ID_W'(MAX_AGENTS)) begin
          a_nxt    = ID_W'(1);
          head_nxt = '0;
          tail_nxt = '0;
          state_nxt = (cur_agents_r == '0) ? ST_IDLE : ST_L_RD;
        end
      end
      // Layering: seed the queue with every unmatched agent, then search breadth-first.
      ST_L_RD: state_nxt = ST_L_WR;
      ST_L_WR: begin
        dist_we = 1'b1;
        if (ap_rd == '0) begin
          dist_wdata = '0;
          que_we   = 1'b1;
          tail_nxt = tail_r + 1'b1;
        end
        a_nxt = a_r + 1'b1;
        if (a_r == cur_agents_r) begin
          state_nxt = ST_L_D0;
        end else begin
          state_nxt = ST_L_RD;
        end
      end
      ST_L_D0: begin
        dist_we    = 1'b1;
        dist_waddr = '0;
        dist0_nxt  = DIST_INF;
        state_nxt  = ST_B_POP;
      end
      ST_B_POP: begin
        ag_nxt = ID_W'(1);
        if (head_r == tail_r) begin
          state_nxt = (dist0_r == DIST_INF) ? ST_O_RD : ST_U_NEXT;
        end else begin
          head_nxt  = head_r + 1'b1;
          state_nxt = ST_B_QA;
        end
      end
      ST_B_QA: begin
        a_nxt      = que_rd;
        dist_raddr = que_rd;
        state_nxt  = ST_B_DA;
      end
      ST_B_DA: begin
        da_nxt = dist_rd;
        s_nxt  = '0;
        state_nxt = cmp.below0 ? ST_B_SLOT : ST_B_POP;
      end
      ST_B_SLOT: state_nxt = (s_r >= cur_prefs_r) ? ST_B_POP : ST_B_H;
      ST_B_H: begin
        h_nxt = pref_rd;
        if (cmp.house_ok) begin
          state_nxt = ST_B_O;
        end else begin
          s_nxt     = s_r + 1'b1;
          state_nxt = ST_B_SLOT;
        end
      end
      ST_B_O: begin
        o_nxt      = hp_rd;
        dist_raddr = hp_rd;
        state_nxt  = ST_B_DO;
      end
      ST_B_DO: begin
        if (cmp.dist_inf) begin
          dist_we    = 1'b1;
          dist_waddr = o_r;
          dist_wdata = dist_inc;
          if (o_r == '0) begin
            dist0_nxt = dist_inc;
          end else begin
            que_we    = 1'b1;
            que_wdata = o_r;
            tail_nxt  = tail_r + 1'b1;
          end
        end
        s_nxt     = s_r + 1'b1;
        state_nxt = ST_B_SLOT;
      end
      // Augmenting: agents in order, depth-first with an explicit stack.
      ST_U_NEXT: begin
        ap_raddr = ag_r;
        if (ag_r > cur_agents_r) begin
          a_nxt    = ID_W'(1);
          head_nxt = '0;
          tail_nxt = '0;
          state_nxt = ST_L_RD;
        end else begin
          state_nxt = ST_U_PT;
        end
      end
      ST_U_PT: begin
        dist_raddr = ag_r;
        if (ap_rd != '0) begin
          ag_nxt    = ag_r + 1'b1;
          state_nxt = ST_U_NEXT;
        end else begin
          a_nxt     = ag_r;
          sp_nxt    = '0;
          state_nxt = ST_D_DA;
        end
      end
      ST_D_DA: begin
        da_nxt    = dist_rd;
        s_nxt     = '0;
        state_nxt = ST_D_SLOT;
      end
      ST_D_SLOT: begin
        if (s_r >= cur_prefs_r) begin
          // Dead end: this agent is dropped from the layering.
          dist_we = 1'b1;
          if (sp_r == '0) begin
            ag_nxt    = ag_r + 1'b1;
            state_nxt = ST_U_NEXT;
          end else begin
            sp_nxt    = sp_m1;
            state_nxt = ST_D_POP;
          end
        end else begin
          state_nxt = ST_D_H;
        end
      end
      ST_D_H: begin
        h_nxt = pref_rd;
        if (cmp.house_ok) begin
          state_nxt = ST_D_O;
        end else begin
          s_nxt     = s_r + 1'b1;
          state_nxt = ST_D_SLOT;
        end
      end
      ST_D_O: begin
        o_nxt      = hp_rd;
        dist_raddr = hp_rd;
        state_nxt  = ST_D_DO;
      end
      ST_D_DO: begin
        if (cmp.dist_next) begin
          if (o_r == '0) begin
            state_nxt = ST_D_SUCC;
          end else begin
            stk_we    = 1'b1;
            sp_nxt    = sp_r + 1'b1;
            a_nxt     = o_r;
            da_nxt    = dist_inc;
            s_nxt     = '0;
            state_nxt = ST_D_SLOT;
          end
        end else begin
          s_nxt     = s_r + 1'b1;
          state_nxt = ST_D_SLOT;
        end
      end
      ST_D_POP: begin
        a_nxt  = stk_rd.agent;
        da_nxt = stk_rd.lvl;
        h_nxt  = stk_rd.house;
        s_nxt  = {1'b0, stk_rd.slot} + 1'b1;
        state_nxt = ST_D_SLOT;
      end
      ST_D_SUCC: begin
        hp_we = 1'b1;  hp_waddr = h_r;  hp_wdata = a_r;
        ap_we = 1'b1;  ap_waddr = a_r;  ap_wdata = h_r;
        if (sp_r == '0) begin
          pair_count_nxt = pair_count_r + 1'b1;
          ag_nxt    = ag_r + 1'b1;
          state_nxt = ST_U_NEXT;
        end else begin
          sp_nxt    = sp_m1;
          state_nxt = ST_D_UPOP;
        end
      end
      ST_D_UPOP: begin
        a_nxt = stk_rd.agent;
        h_nxt = stk_rd.house;
        state_nxt = ST_D_SUCC;
      end
      ST_O_RD: begin
        ap_raddr  = ag_r;
        state_nxt = ST_O_LD;
      end
      ST_O_LD: begin
        oag_nxt    = ag_r;
        ohouse_nxt = ap_rd;
        olast_nxt  = (ag_r == cur_agents_r);
        state_nxt  = ST_O_WAIT;
      end
      ST_O_WAIT: begin
        if (out_ready) begin
          ag_nxt    = ag_r + 1'b1;
          state_nxt = olast_r ? ST_IDLE : ST_O_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while results pending");
  a_queue: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= tail_r) else $error("queue head passed tail");
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_D_SUCC && sp_r == '0) |=> pair_count_r == $past(pair_count_r) + 1'b1)
    else $error("pair count not advanced on augmentation");
  a_more: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_result) |=> !in_ready)
    else $error("run ended before last result");

endmodule

@@ rtl/bmm_ram.sv @@
module bmm_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/bmm_cmp.sv @@
module bmm_cmp import bmm_pkg::*; (
  input  logic [ID_W-1:0]   house,
  input  logic [ID_W-1:0]   cur_houses,
  input  logic [DIST_W-1:0] dist_rd,
  input  logic [DIST_W-1:0] dist_cur,
  input  logic [DIST_W-1:0] dist_zero,
  output logic [DIST_W-1:0] dist_inc,
  output bmm_cmp_t          res
);

  assign dist_inc     = dist_cur + 1'b1;
  assign res.house_ok  = (house != '0) && (house <= cur_houses);
  assign res.dist_inf  = (dist_rd == DIST_INF);
  assign res.dist_next = (dist_rd == dist_inc);
  assign res.below0    = (dist_rd < dist_zero);

endmodule
